// ----- rtl/marlb_pkg.sv -----
// Shared types, codes and widths for the rate limiter bank.
// Used by the controller, the datapath and the top level.
package marlb_pkg;

	localparam int NUM_ENTRIES_DEF = 8;
	localparam int LEVEL_BITS_DEF = 16;
	localparam int TIME_BITS = 32;
	localparam int FIELD_BITS = 16;
	localparam int IDX_W = 3;
	localparam int KIND_W = 3;

	localparam logic [2:0] KIND_TOKEN = 3'd0;
	localparam logic [2:0] KIND_SLIDING = 3'd1;
	localparam logic [2:0] KIND_LEAKY = 3'd2;
	localparam logic [2:0] KIND_FIXED = 3'd3;
	localparam logic [2:0] KIND_CONC = 3'd4;
	localparam int KIND_SPACE = 8;

	localparam logic [1:0] REQ_CREATE = 2'd0;
	localparam logic [1:0] REQ_CHECK = 2'd1;
	localparam logic [1:0] REQ_RELEASE = 2'd2;
	localparam logic [1:0] REQ_ADVANCE = 2'd3;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_REJECT = 2'd1;
	localparam logic [1:0] ST_NO_ENTRY = 2'd2;
	localparam logic [1:0] ST_FULL = 2'd3;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;      // capture the request and read the entry
		logic math;      // compute elapsed time and products
		logic div_start; // start the modulo unit
		logic div_step;  // one restoring step
		logic finish;    // update entry and form the result
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic need_div; // valid fixed-window check with nonzero window
		logic div_done;
	} sts_t;

endpackage

// ----- rtl/marlb_ctrl.sv -----
// Controller state machine for the rate limiter bank.
// Depends on marlb_pkg for the command and status structs.
module marlb_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_fire,
	input  logic out_free,
	input  marlb_pkg::sts_t sts,
	output marlb_pkg::cmd_t cmd,
	output logic busy
);
	import marlb_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MATH = 3'd1;
	localparam logic [2:0] S_DIVS = 3'd2;
	localparam logic [2:0] S_DIV = 3'd3;
	localparam logic [2:0] S_FIN = 3'd4;

	logic [2:0] state_q, state_d;

	// Next state and command decode.
	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					cmd.load = 1'b1;
					state_d = S_MATH;
				end
			end
			S_MATH: begin
				cmd.math = 1'b1;
				state_d = S_DIVS;
			end
			S_DIVS: begin
				if (sts.need_div) begin
					cmd.div_start = 1'b1;
					state_d = S_DIV;
				end else begin
					state_d = S_FIN;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_done) state_d = S_FIN;
			end
			S_FIN: begin
				if (out_free) begin
					cmd.finish = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign busy = (state_q != S_IDLE);

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end
endmodule

// ----- rtl/marlb_dp.sv -----
// Datapath of the rate limiter bank: entry table, time counter, products and modulo unit.
// Depends on marlb_pkg; commanded by marlb_ctrl.
module marlb_dp #(
	parameter int NUM_ENTRIES = marlb_pkg::NUM_ENTRIES_DEF,
	parameter int LEVEL_BITS = marlb_pkg::LEVEL_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  marlb_pkg::cmd_t cmd,
	output marlb_pkg::sts_t sts,
	input  logic [1:0] req_type,
	input  logic [2:0] entry_index,
	input  logic [2:0] limiter_kind,
	input  logic [15:0] limit,
	input  logic [15:0] rate,
	input  logic [31:0] window,
	input  logic [15:0] time_step,
	output logic [1:0] status,
	output logic [2:0] assigned_index,
	output logic [15:0] level
);
	import marlb_pkg::*;

	localparam int EW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
	localparam int CW = $clog2(NUM_ENTRIES + 1);
	localparam logic [LEVEL_BITS-1:0] LMAX = '1;
	localparam int PW = 48;

	// Bucket size clamped to the level width.
	function automatic logic [LEVEL_BITS-1:0] limit_cap(input logic [15:0] v);
		return (LEVEL_BITS >= 16) ? LEVEL_BITS'(v) :
			((v > 16'(LMAX)) ? LMAX : LEVEL_BITS'(v));
	endfunction

	// Entry table.
	logic [2:0]            kind_m [NUM_ENTRIES];
	logic [15:0]           lim_m  [NUM_ENTRIES];
	logic [15:0]           rate_m [NUM_ENTRIES];
	logic [31:0]           win_m  [NUM_ENTRIES];
	logic [LEVEL_BITS-1:0] lvl_m  [NUM_ENTRIES];
	logic [31:0]           stamp_m[NUM_ENTRIES];

	logic [31:0] now_q;
	logic [CW-1:0] used_q;

	// Captured request and entry.
	logic [1:0] req_q;
	logic [2:0] idx_q, nkind_q;
	logic [15:0] nlim_q, nrate_q, step_q;
	logic [31:0] nwin_q;
	logic [EW-1:0] addr_q;
	logic valid_q;
	logic [2:0] kind_q;
	logic [LEVEL_BITS-1:0] cap_q, lvl_q;
	logic [15:0] rate_q;
	logic [31:0] win_q, stamp_q, el_q;
	logic [PW-1:0] amt_q;
	logic ge_w_q;

	// Modulo unit: restoring division of el by window.
	logic [31:0] dq_q, dr_q;
	logic [5:0] dcnt_q;
	logic [33:0] trial;
	logic [32:0] rem_shift;

	logic [EW-1:0] addr_d;
	logic fits;

	always_comb begin
		addr_d = entry_index[EW-1:0];
		fits = ({29'd0, entry_index} < 32'(NUM_ENTRIES))
			&& ({{(32-CW){1'b0}}, used_q} > {29'd0, entry_index});
		if (req_type == REQ_CREATE) addr_d = used_q[EW-1:0];
	end

	// The partial remainder keeps its top bit, since windows may exceed 2^31.
	assign rem_shift = {dr_q, dq_q[31]};
	assign trial = {1'b0, rem_shift} - {2'b00, win_q};
	assign sts = '{need_div: (kind_q == KIND_FIXED) && (win_q != 32'd0)
			&& (req_q == REQ_CHECK) && valid_q,
		div_done: (dcnt_q == 6'd0)};

	// Next-state entry update.
	logic [LEVEL_BITS-1:0] nl;
	logic [31:0] nstamp;
	logic [1:0] nst;
	logic [PW-1:0] sum;
	logic [LEVEL_BITS-1:0] cap_c;

	always_comb begin
		nl = lvl_q;
		nstamp = stamp_q;
		nst = ST_OK;
		cap_c = limit_cap(nlim_q);
		sum = PW'(lvl_q) + amt_q;
		case (kind_q)
			KIND_TOKEN: begin
				if (amt_q != '0) begin
					nl = (sum > PW'(cap_q)) ? cap_q : LEVEL_BITS'(sum);
					nstamp = now_q;
				end
			end
			KIND_SLIDING: begin
				if (ge_w_q) begin
					nl = '0;
					nstamp = now_q;
				end
			end
			KIND_LEAKY: begin
				if (amt_q != '0) begin
					nl = (PW'(lvl_q) > amt_q) ? LEVEL_BITS'(PW'(lvl_q) - amt_q) : '0;
					nstamp = now_q;
				end
			end
			KIND_FIXED: begin
				if (win_q == 32'd0) begin
					nl = '0;
					nstamp = now_q;
				end else if (el_q >= win_q) begin
					// Quotient nonzero: realign to now minus remainder.
					nl = '0;
					nstamp = now_q - dr_q;
				end
			end
			default: ;
		endcase
		if (kind_q == KIND_TOKEN) begin
			if (nl != '0) nl = nl - 1'b1;
			else nst = ST_REJECT;
		end else if (kind_q <= KIND_CONC) begin
			if (nl < cap_q) nl = nl + 1'b1;
			else nst = ST_REJECT;
		end else begin
			nst = ST_REJECT;
		end
	end

	// Result fields for the finishing request.
	logic [1:0] res_status;
	logic [2:0] res_index;
	logic [15:0] res_level;

	always_comb begin
		res_status = ST_OK;
		res_index = idx_q;
		res_level = '0;
		case (req_q)
			REQ_CREATE: begin
				if (used_q >= CW'(NUM_ENTRIES)) begin
					res_status = ST_FULL;
					res_index = '0;
				end else begin
					res_index = 3'(used_q);
					res_level = (nkind_q == KIND_TOKEN) ? 16'(cap_c) : 16'd0;
				end
			end
			REQ_CHECK: begin
				if (!valid_q) res_status = ST_NO_ENTRY;
				else begin
					res_status = nst;
					res_level = 16'(nl);
				end
			end
			REQ_RELEASE: begin
				if (!valid_q) res_status = ST_NO_ENTRY;
				else if (kind_q == KIND_CONC && lvl_q != '0) res_level = 16'(lvl_q - 1'b1);
				else res_level = 16'(lvl_q);
			end
			default: ;
		endcase
	end

	// Time counter and entry count update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q <= '0;
			used_q <= '0;
		end else if (cmd.finish) begin
			case (req_q)
				REQ_CREATE: begin
					if (used_q < CW'(NUM_ENTRIES)) used_q <= used_q + 1'b1;
				end
				REQ_ADVANCE: now_q <= now_q + {16'd0, step_q};
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req_type;
			idx_q <= entry_index;
			nkind_q <= limiter_kind;
			nlim_q <= limit;
			nrate_q <= rate;
			nwin_q <= window;
			step_q <= time_step;
			addr_q <= addr_d;
			valid_q <= fits;
			kind_q <= kind_m[addr_d];
			cap_q <= limit_cap(lim_m[addr_d]);
			lvl_q <= lvl_m[addr_d];
			rate_q <= rate_m[addr_d];
			win_q <= win_m[addr_d];
			stamp_q <= stamp_m[addr_d];
		end
		if (cmd.math) begin
			el_q <= now_q - stamp_q;
			amt_q <= PW'(now_q - stamp_q) * PW'(rate_q);
			ge_w_q <= (now_q - stamp_q) >= win_q;
		end
		if (cmd.div_start) begin
			dq_q <= el_q;
			dr_q <= '0;
			dcnt_q <= 6'd32;
		end else if (cmd.div_step && dcnt_q != 6'd0) begin
			dcnt_q <= dcnt_q - 1'b1;
			if (!trial[33]) begin
				dr_q <= trial[31:0];
				dq_q <= {dq_q[30:0], 1'b1};
			end else begin
				dr_q <= rem_shift[31:0];
				dq_q <= {dq_q[30:0], 1'b0};
			end
		end
		if (cmd.finish) begin
			status <= res_status;
			assigned_index <= res_index;
			level <= res_level;
			case (req_q)
				REQ_CREATE: begin
					if (used_q < CW'(NUM_ENTRIES)) begin
						kind_m[addr_q] <= nkind_q;
						lim_m[addr_q] <= nlim_q;
						rate_m[addr_q] <= nrate_q;
						win_m[addr_q] <= nwin_q;
						stamp_m[addr_q] <= now_q;
						lvl_m[addr_q] <= (nkind_q == KIND_TOKEN) ? cap_c : '0;
					end
				end
				REQ_CHECK: begin
					if (valid_q) begin
						lvl_m[addr_q] <= nl;
						stamp_m[addr_q] <= nstamp;
					end
				end
				REQ_RELEASE: begin
					if (valid_q && kind_q == KIND_CONC && lvl_q != '0)
						lvl_m[addr_q] <= lvl_q - 1'b1;
				end
				default: ;
			endcase
		end
	end
endmodule

// ----- rtl/multi_algorithm_rate_limiter_bank.sv -----
// Top level of the rate limiter bank: stream ports, output register, assertions.
// Depends on marlb_pkg, marlb_ctrl and marlb_dp.
//
// Channel  Dir  Fields (low bit up)
// s_axis   in   tdata: req_type, entry_index, limiter_kind, limit, rate, window, time_step
// m_axis   out  tdata: status, assigned_index, level
//
// A request passes the load, math, divide-decision and finish states; a fixed-window
// check also runs the 32-step restoring modulo unit. One request is in work at a time.
// Reset clears the controller, time counter and entry count; no clearing pass.
// A stalled result holds; the next request is still taken and worked, and its
// finishing step waits until the held result has been read.
module multi_algorithm_rate_limiter_bank #(
	parameter int NUM_ENTRIES = marlb_pkg::NUM_ENTRIES_DEF,
	parameter int LEVEL_BITS = marlb_pkg::LEVEL_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// req_type[1:0], entry_index[4:2], limiter_kind[7:5], limit[23:8],
	// rate[39:24], window[71:40], time_step[87:72]
	input  logic [87:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// status[1:0], assigned_index[4:2], level[20:5]
	output logic [23:0] m_axis_tdata
);
	import marlb_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic busy, in_fire, out_free, ovalid_q;
	logic [1:0] status;
	logic [2:0] aidx;
	logic [15:0] lvl;

	assign s_axis_tready = !busy;
	assign in_fire = s_axis_tvalid && s_axis_tready;
	assign out_free = !ovalid_q || m_axis_tready;

	marlb_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .out_free(out_free),
		.sts(sts), .cmd(cmd), .busy(busy)
	);

	marlb_dp #(.NUM_ENTRIES(NUM_ENTRIES), .LEVEL_BITS(LEVEL_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.req_type(s_axis_tdata[1:0]), .entry_index(s_axis_tdata[4:2]),
		.limiter_kind(s_axis_tdata[7:5]), .limit(s_axis_tdata[23:8]),
		.rate(s_axis_tdata[39:24]), .window(s_axis_tdata[71:40]),
		.time_step(s_axis_tdata[87:72]),
		.status(status), .assigned_index(aidx), .level(lvl)
	);

	// Output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ovalid_q <= 1'b0;
		else if (cmd.finish) ovalid_q <= 1'b1;
		else if (m_axis_tready) ovalid_q <= 1'b0;
	end

	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata = {3'd0, lvl, aidx, status};

	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.math, cmd.div_start, cmd.div_step, cmd.finish}))
		else $error("more than one datapath command");
	a_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> busy)
		else $error("controller idle after accepting a request");
	a_fin_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> m_axis_tvalid)
		else $error("result not presented after finish");
endmodule
